@@ design/wfrm_pkg.sv @@
// Package for the windowed frame rate meter: types, sizes and constants.
package wfrm_pkg;

	localparam int WINDOW_SAMPLES = 60;
	localparam int INTERVAL_BITS  = 32;
	localparam int FRACTION_BITS  = 16;

	localparam int TIME_W  = 64;
	localparam int RATE_W  = 32;
	localparam int SLOT_W  = $clog2(WINDOW_SAMPLES);
	localparam int CNT_W   = $clog2(WINDOW_SAMPLES + 1);
	localparam int SUM_W   = INTERVAL_BITS + $clog2(WINDOW_SAMPLES);
	localparam int NS_W    = 30;
	localparam int PROD_W  = CNT_W + NS_W;
	localparam int NUM_W   = PROD_W + FRACTION_BITS;
	localparam int STEP_W  = $clog2(NUM_W + 1);

	localparam logic [NS_W-1:0] NS_PER_SECOND = NS_W'(1000000000);

	typedef struct packed {
		logic [TIME_W-1:0] time_ns;
		logic              time_ok;
	} sample_t;

	typedef struct packed {
		logic [RATE_W-1:0] rate_q16;
		logic              rate_saturated;
	} rate_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_SUM,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

@@ design/wfrm_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
module wfrm_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [wfrm_pkg::NUM_W-1:0]    num,
	input  logic [wfrm_pkg::SUM_W-1:0]    den,
	output logic                          done,
	output logic [wfrm_pkg::NUM_W-1:0]    quot
);

	logic                          busy_q;
	logic                          done_q;
	logic [wfrm_pkg::STEP_W-1:0]   step_q;
	logic [wfrm_pkg::SUM_W-1:0]    den_q;
	logic [wfrm_pkg::SUM_W-1:0]    rem_q;
	logic [wfrm_pkg::NUM_W-1:0]    quo_q;

	logic [wfrm_pkg::SUM_W:0]      rem_shift;
	logic [wfrm_pkg::SUM_W:0]      rem_diff;
	logic                          fits;

	// shift in next dividend bit, trial subtract
	assign rem_shift = {rem_q, quo_q[wfrm_pkg::NUM_W-1]};
	assign rem_diff  = rem_shift - {1'b0, den_q};
	assign fits      = (rem_shift >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == wfrm_pkg::STEP_W'(wfrm_pkg::NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? rem_diff[wfrm_pkg::SUM_W-1:0] : rem_shift[wfrm_pkg::SUM_W-1:0];
			quo_q <= {quo_q[wfrm_pkg::NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

@@ design/windowed_frame_rate_meter.sv @@
// Windowed frame rate meter: top level, sequencer, interval ring and running sum.
// Sequence: ST_IDLE takes the sample, ST_PREP forms the interval; a failed read or the
// seeding stamp goes to ST_DONE, else ST_SUM, ST_MUL, for a nonzero sum ST_DIV, then ST_DONE.
// Throughput: one sample at a time; sample_stall stays high until the sequencer is idle,
// which ST_DONE delays while rate_stall holds a result.
// Reset: arst_n clears sum, fill count, slot, seed flag and previous stamp at once;
// ring slots beyond the fill count read as zero, so the ring itself needs no clearing.
module windowed_frame_rate_meter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  wfrm_pkg::sample_t sample,
	output logic              rate_valid,
	input  logic              rate_stall,
	output wfrm_pkg::rate_t   rate
);

	localparam logic [wfrm_pkg::INTERVAL_BITS-1:0] INTERVAL_MAX = '1;

	wfrm_pkg::state_t state_q, state_d;

	// working registers
	wfrm_pkg::sample_t                   sample_q;
	logic [wfrm_pkg::TIME_W-1:0]         prev_q;
	logic                                seeded_q;
	logic [wfrm_pkg::SUM_W-1:0]          sum_q;
	logic [wfrm_pkg::SLOT_W-1:0]         slot_q;
	logic [wfrm_pkg::CNT_W-1:0]          count_q;
	logic [wfrm_pkg::INTERVAL_BITS-1:0]  iv_q;
	logic [wfrm_pkg::NUM_W-1:0]          num_q;
	wfrm_pkg::rate_t                     res_q;

	// interval ring
	logic [wfrm_pkg::INTERVAL_BITS-1:0]  ring_mem [wfrm_pkg::WINDOW_SAMPLES];
	logic [wfrm_pkg::INTERVAL_BITS-1:0]  ring_rd_q;

	// output register
	wfrm_pkg::rate_t                     rate_q;
	logic                                rate_valid_q;

	// sequencer outputs
	logic                                take;
	logic                                ring_re;
	logic                                ring_we;
	logic                                div_start;
	logic                                load_out;

	logic                                div_start_q;
	logic                                div_done;
	logic [wfrm_pkg::NUM_W-1:0]          div_quot;

	// interval: backward time is zero, long gaps saturate
	logic [wfrm_pkg::TIME_W:0]           diff;
	logic [wfrm_pkg::INTERVAL_BITS-1:0]  iv_d;
	logic                                full;
	logic [wfrm_pkg::INTERVAL_BITS-1:0]  old_iv;
	logic [wfrm_pkg::PROD_W-1:0]         prod;

	assign diff = {1'b0, sample_q.time_ns} - {1'b0, prev_q};

	always_comb begin
		if (diff[wfrm_pkg::TIME_W])
			iv_d = '0;
		else if (diff[wfrm_pkg::TIME_W-1:wfrm_pkg::INTERVAL_BITS] != '0)
			iv_d = INTERVAL_MAX;
		else
			iv_d = diff[wfrm_pkg::INTERVAL_BITS-1:0];
	end

	// before the ring wraps, the slot being replaced was never written
	assign full   = (count_q == wfrm_pkg::CNT_W'(wfrm_pkg::WINDOW_SAMPLES));
	assign old_iv = full ? ring_rd_q : '0;
	assign prod   = wfrm_pkg::PROD_W'(count_q) * wfrm_pkg::PROD_W'(wfrm_pkg::NS_PER_SECOND);

	// sequencer
	always_comb begin
		state_d   = state_q;
		take      = 1'b0;
		ring_re   = 1'b0;
		ring_we   = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			wfrm_pkg::ST_IDLE: begin
				if (sample_valid) begin
					take    = 1'b1;
					state_d = wfrm_pkg::ST_PREP;
				end
			end
			wfrm_pkg::ST_PREP: begin
				if (sample_q.time_ok && seeded_q) begin
					ring_re = 1'b1;
					state_d = wfrm_pkg::ST_SUM;
				end else begin
					state_d = wfrm_pkg::ST_DONE;
				end
			end
			wfrm_pkg::ST_SUM: begin
				ring_we = 1'b1;
				state_d = wfrm_pkg::ST_MUL;
			end
			wfrm_pkg::ST_MUL: begin
				if (sum_q == '0) begin
					state_d = wfrm_pkg::ST_DONE;
				end else begin
					div_start = 1'b1;
					state_d   = wfrm_pkg::ST_DIV;
				end
			end
			wfrm_pkg::ST_DIV: begin
				if (div_done)
					state_d = wfrm_pkg::ST_DONE;
			end
			wfrm_pkg::ST_DONE: begin
				if (!rate_valid_q || !rate_stall) begin
					load_out = 1'b1;
					state_d  = wfrm_pkg::ST_IDLE;
				end
			end
			default: state_d = wfrm_pkg::ST_IDLE;
		endcase
	end

	assign sample_stall = (state_q != wfrm_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= wfrm_pkg::ST_IDLE;
			prev_q       <= '0;
			seeded_q     <= 1'b0;
			sum_q        <= '0;
			slot_q       <= '0;
			count_q      <= '0;
			rate_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == wfrm_pkg::ST_PREP && sample_q.time_ok) begin
				seeded_q <= 1'b1;
				prev_q   <= sample_q.time_ns;
			end
			if (ring_we) begin
				sum_q  <= sum_q - wfrm_pkg::SUM_W'(old_iv) + wfrm_pkg::SUM_W'(iv_q);
				slot_q <= (slot_q == wfrm_pkg::SLOT_W'(wfrm_pkg::WINDOW_SAMPLES - 1)) ?
					'0 : slot_q + 1'b1;
				if (!full)
					count_q <= count_q + 1'b1;
			end
			if (load_out)
				rate_valid_q <= 1'b1;
			else if (!rate_stall)
				rate_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take)
			sample_q <= sample;
		if (state_q == wfrm_pkg::ST_PREP) begin
			iv_q  <= iv_d;
			res_q <= '0;
		end
		if (state_q == wfrm_pkg::ST_MUL)
			num_q <= wfrm_pkg::NUM_W'(prod) << wfrm_pkg::FRACTION_BITS;
		if (div_done) begin
			if (div_quot[wfrm_pkg::NUM_W-1:wfrm_pkg::RATE_W] != '0) begin
				res_q.rate_q16       <= '1;
				res_q.rate_saturated <= 1'b1;
			end else begin
				res_q.rate_q16       <= div_quot[wfrm_pkg::RATE_W-1:0];
				res_q.rate_saturated <= 1'b0;
			end
		end
		if (load_out)
			rate_q <= res_q;
	end

	// ring: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (ring_we)
			ring_mem[slot_q] <= iv_q;
		if (ring_re)
			ring_rd_q <= ring_mem[slot_q];
	end

	// start is registered, so the divider starts in the cycle after ST_MUL, with the numerator already registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			div_start_q <= 1'b0;
		else
			div_start_q <= div_start;
	end

	// num_q is written in ST_MUL and read by the divider on the following start edge
	wfrm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (num_q),
		.den    (sum_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign rate_valid = rate_valid_q;
	assign rate       = rate_q;

	// fill count never passes the window
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= wfrm_pkg::CNT_W'(wfrm_pkg::WINDOW_SAMPLES))
		else $error("fill count beyond window");

	// slot stays inside the ring
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q < wfrm_pkg::SLOT_W'(wfrm_pkg::WINDOW_SAMPLES))
		else $error("ring slot out of range");

	// empty ring means zero sum
	a_empty_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (sum_q == '0))
		else $error("nonzero sum with empty ring");

	// divider finishes only while the sequencer waits on it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == wfrm_pkg::ST_DIV))
		else $error("divider done outside divide state");

	// saturation flag always comes with an all-ones rate
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(rate_valid && rate.rate_saturated) |-> (rate.rate_q16 == '1))
		else $error("saturated rate not at maximum");

endmodule

@@ verif/testbench.sv @@
// Self-checking regression for the windowed frame rate meter, with its own rate predictor.
`timescale 1ns / 1ps

module testbench;

	// Interval clamp and rate ceiling at the block's widths.
	localparam logic [63:0] SPAN_MAX = (64'd1 << wfrm_pkg::INTERVAL_BITS) - 64'd1;
	localparam logic [63:0] RATE_CEIL = 64'hFFFF_FFFF;
	localparam logic [63:0] ONE_SECOND_NS = 64'd1_000_000_000;
	localparam logic [63:0] FRAME_60HZ_NS = 64'd16_666_667;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	// Every input starts at a known value; arst_n is held low from time zero.
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              sample_valid = 1'b0;
	logic              sample_stall;
	wfrm_pkg::sample_t sample = '0;
	logic              rate_valid;
	logic              rate_stall = 1'b0;
	wfrm_pkg::rate_t   rate;

	windowed_frame_rate_meter i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.rate_valid   (rate_valid),
		.rate_stall   (rate_stall),
		.rate         (rate)
	);

	// 10 ns clock: low half then high half.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predicted meter state: ring of recent frame spans, exact sum, slot, fill, last stamp.
	logic [wfrm_pkg::INTERVAL_BITS-1:0] span_ring [wfrm_pkg::WINDOW_SAMPLES];
	logic [63:0]              span_sum;
	int unsigned              ring_slot;
	int unsigned              ring_fill;
	logic [63:0]              last_stamp;
	bit                       timer_seeded;

	// Rates predicted for accepted samples, oldest first.
	wfrm_pkg::rate_t rate_expect [$];

	int unsigned mismatches = 0;

	// Pacing knobs shared by the tests.
	bit          tx_jitter = 1'b0;
	bit          rx_jitter = 1'b0;
	bit          hold_off = 1'b0;
	int unsigned stall_left = 0;

	initial begin
		for (int i = 0; i < wfrm_pkg::WINDOW_SAMPLES; i++)
			span_ring[i] = '0;
		span_sum = '0;
		ring_slot = 0;
		ring_fill = 0;
		last_stamp = '0;
		timer_seeded = 1'b0;
	end

	// Advance the predicted meter by one sample and return the rate it reports.
	function automatic wfrm_pkg::rate_t meter_step(input wfrm_pkg::sample_t s);
		wfrm_pkg::rate_t r;
		logic [63:0] span;
		logic [63:0] numer;
		logic [63:0] quot;
		r = '0;
		if (s.time_ok) begin
			if (!timer_seeded) begin
				// first good stamp only starts the timer
				timer_seeded = 1'b1;
			end else begin
				// backward time counts as a zero span; long gaps clamp
				if (s.time_ns < last_stamp)
					span = '0;
				else
					span = s.time_ns - last_stamp;
				if (span > SPAN_MAX)
					span = SPAN_MAX;
				span_sum = span_sum - 64'(span_ring[ring_slot]) + span;
				span_ring[ring_slot] = span[wfrm_pkg::INTERVAL_BITS-1:0];
				ring_slot = (ring_slot + 1) % wfrm_pkg::WINDOW_SAMPLES;
				if (ring_fill < wfrm_pkg::WINDOW_SAMPLES)
					ring_fill++;
				// frames * 1e9 / sum, fixed point, truncated; zero sum reports zero
				if (span_sum != 0) begin
					numer = (64'(ring_fill) * ONE_SECOND_NS) << wfrm_pkg::FRACTION_BITS;
					quot = numer / span_sum;
					if (quot > RATE_CEIL) begin
						r.rate_q16 = '1;
						r.rate_saturated = 1'b1;
					end else begin
						r.rate_q16 = quot[wfrm_pkg::RATE_W-1:0];
					end
				end
			end
			last_stamp = s.time_ns;
		end
		return r;
	endfunction

	function automatic wfrm_pkg::sample_t frame(input logic [63:0] t, input logic ok);
		wfrm_pkg::sample_t s;
		s.time_ns = t;
		s.time_ok = ok;
		return s;
	endfunction

	// Idle length: picked at random, now and then a long one.
	function automatic int unsigned pick_gap();
		if ($urandom_range(9) == 0)
			return $urandom_range(20, 120);
		return $urandom_range(1, 3);
	endfunction

	// Span to the next frame: real frame times dominate, with zero, tiny
	// (some saturating) and very long spans mixed in.
	function automatic logic [63:0] pick_span();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 5)
			return '0;
		if (roll < 20)
			return 64'($urandom_range(1, 30000));
		if (roll < 75)
			return 64'($urandom_range(8_000_000, 50_000_000));
		if (roll < 90)
			return {32'd0, $urandom};
		return {24'd0, 8'($urandom_range(255)), $urandom};
	endfunction

	// Random sample: mostly a well-formed next frame, the rest failed reads,
	// stamps anywhere in the 64-bit range, and time running backward.
	function automatic wfrm_pkg::sample_t random_frame();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 8)
			return frame({$urandom, $urandom}, 1'b0);
		if (roll < 14)
			return frame({$urandom, $urandom}, 1'b1);
		if (roll < 20)
			return frame(last_stamp - {32'd0, $urandom} - 64'd1, 1'b1);
		return frame(last_stamp + pick_span(), 1'b1);
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 100)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	// One sample transfer: present at the falling edge, hold until accepted.
	// Valid stays high afterward so back-to-back transfers need no extra edge.
	task automatic send_sample(input wfrm_pkg::sample_t s);
		@(negedge clk);
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (sample_stall);
		rate_expect.push_back(meter_step(s));
	endtask

	task automatic pause_sender();
		int unsigned n;
		if (tx_jitter && $urandom_range(2) == 0) begin
			n = pick_gap();
			@(negedge clk) sample_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Sender goes quiet until every predicted rate has been transferred.
	task automatic wait_drained();
		@(negedge clk) sample_valid <= 1'b0;
		while (rate_expect.size() != 0)
			@(posedge clk);
	endtask

	// Long receiver hold-off, counted in its own process.
	task automatic hold_rates(input int unsigned cycles);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (cycles) @(posedge clk);
		hold_off = 1'b0;
	endtask

	// Receiver pacing: stall bursts of random length, or a forced hold-off.
	always @(negedge clk) begin
		if (hold_off) begin
			rate_stall <= 1'b1;
		end else if (stall_left != 0) begin
			rate_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else if (rx_jitter && $urandom_range(3) == 0) begin
			rate_stall <= 1'b1;
			stall_left = pick_gap() - 1;
		end else begin
			rate_stall <= 1'b0;
		end
	end

	// Each rate transfer is matched against the oldest prediction.
	always @(posedge clk) begin : rate_check
		wfrm_pkg::rate_t want;
		if (arst_n && rate_valid && !rate_stall) begin
			if (rate_expect.size() == 0) begin
				report_mismatch($sformatf("unexpected rate %h sat %b",
					rate.rate_q16, rate.rate_saturated));
			end else begin
				want = rate_expect.pop_front();
				if (rate.rate_q16 !== want.rate_q16)
					report_mismatch($sformatf("rate_q16 got %h want %h",
						rate.rate_q16, want.rate_q16));
				if (rate.rate_saturated !== want.rate_saturated)
					report_mismatch($sformatf("rate_saturated got %b want %b",
						rate.rate_saturated, want.rate_saturated));
			end
		end
	end

	// Corner cases in a fixed order, starting from the reset state.
	task automatic test_directed_cases();
		tx_jitter = 1'b1;
		rx_jitter = 1'b1;
		send_sample(frame(ALL_ONES, 1'b0));              // failed read before seeding
		send_sample(frame(64'd0, 1'b0));
		send_sample(frame(64'd0, 1'b1));                 // seeds the timer
		send_sample(frame(64'd0, 1'b1));                 // zero span, zero sum
		send_sample(frame(64'd1, 1'b1));                 // 1 ns span: saturates
		send_sample(frame(64'd0, 1'b1));                 // backward, still saturated
		send_sample(frame(64'd5, 1'b0));                 // failed read, state kept
		send_sample(frame(ALL_ONES, 1'b1));              // huge span, clamped
		send_sample(frame(ALL_ONES, 1'b1));              // zero span at top of range
		send_sample(frame(64'h8000_0000_0000_0000, 1'b1)); // backward
		send_sample(frame(64'h8000_0000_0000_0000 + FRAME_60HZ_NS, 1'b1));
		send_sample(frame(last_stamp + 64'd16_666_666, 1'b1));
		send_sample(frame(last_stamp + 64'd33_333_333, 1'b1));
		send_sample(frame(last_stamp + 64'd15_258, 1'b1)); // one span near the rate ceiling
		send_sample(frame(last_stamp + SPAN_MAX, 1'b1));   // exactly the clamp
		send_sample(frame(last_stamp + SPAN_MAX + 64'd1, 1'b1));
		send_sample(frame({$urandom, $urandom}, 1'b0));
		wait_drained();
	endtask

	// Steady 60 Hz frames fill the window and wrap it; the first stretch has
	// no idling on either side.
	task automatic test_window_wrap();
		tx_jitter = 1'b0;
		rx_jitter = 1'b0;
		for (int i = 0; i < 200; i++) begin
			if (i == 70) begin
				tx_jitter = 1'b1;
				rx_jitter = 1'b1;
			end
			send_sample(frame(last_stamp + FRAME_60HZ_NS - 64'd1000
				+ 64'($urandom_range(2000)), 1'b1));
			pause_sender();
		end
		wait_drained();
	endtask

	// Receiver holds off while the sender keeps offering: the block backs up
	// and stalls its input. The sender then waits for everything to drain.
	task automatic test_backpressure();
		tx_jitter = 1'b0;
		rx_jitter = 1'b0;
		fork
			hold_rates(400);
		join_none
		for (int i = 0; i < 8; i++)
			send_sample(random_frame());
		wait_drained();
		rx_jitter = 1'b1;
	endtask

	// Bulk random traffic with idling on both sides and periodic full drains.
	task automatic test_random_stream(input int unsigned count);
		tx_jitter = 1'b1;
		rx_jitter = 1'b1;
		for (int unsigned i = 0; i < count; i++) begin
			if (i % 250 == 249)
				wait_drained();
			send_sample(random_frame());
			pause_sender();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		test_directed_cases();
		test_window_wrap();
		test_backpressure();
		test_random_stream(1800);
		wait_drained();
		// grace period: any stray rate transfer here is flagged by the checker
		repeat (150) @(posedge clk);
		if (mismatches == 0)
			$display("windowed_frame_rate_meter regression: pass");
		else
			$display("windowed_frame_rate_meter regression: fail");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#50_000_000;
		$display("windowed_frame_rate_meter regression: fail");
		$finish;
	end

endmodule

@@ files.f @@
design/wfrm_pkg.sv
design/wfrm_div.sv
design/windowed_frame_rate_meter.sv
verif/testbench.sv
